@@ hdl/jsu_pkg.sv @@
// ============================================================================
// jsu_pkg: shared types and helpers for the JSON string unescape core
// Holds the channel payload structs, the job format that travels from the
// front decoder to the back serializer, the status codes and the UTF-8
// encoder.
// ============================================================================
package jsu_pkg;

  // Depth of the job queue between front and back.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // Input item kinds.
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_DATA   = 3'd0;
  localparam logic [2:0] ST_CLOSE  = 3'd1;
  localparam logic [2:0] ST_CTRL   = 3'd2;
  localparam logic [2:0] ST_BADU   = 3'd3;
  localparam logic [2:0] ST_BADESC = 3'd4;
  localparam logic [2:0] ST_EOF    = 3'd5;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;
  } out_item_t;

  // One result without its last flag.
  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
  } res_t;

  // All results caused by one input item; res[0] goes out first.
  typedef struct packed {
    res_t [3:0] res;
    logic [1:0] last_idx;
  } job_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // UTF-8 bytes of one code point; bytes[0] is sent first.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
  } enc_t;

  function automatic enc_t utf8_encode(input logic [20:0] pt);
    enc_t e;
    e = '0;
    if (pt < 21'h80) begin
      e.bytes[0] = {1'b0, pt[6:0]};
      e.cnt      = 3'd1;
    end else if (pt < 21'h800) begin
      e.bytes[0] = {3'b110, pt[10:6]};
      e.bytes[1] = {2'b10, pt[5:0]};
      e.cnt      = 3'd2;
    end else if (pt < 21'h10000) begin
      e.bytes[0] = {4'b1110, pt[15:12]};
      e.bytes[1] = {2'b10, pt[11:6]};
      e.bytes[2] = {2'b10, pt[5:0]};
      e.cnt      = 3'd3;
    end else begin
      e.bytes[0] = {5'b11110, pt[20:18]};
      e.bytes[1] = {2'b10, pt[17:12]};
      e.bytes[2] = {2'b10, pt[11:6]};
      e.bytes[3] = {2'b10, pt[5:0]};
      e.cnt      = 3'd4;
    end
    return e;
  endfunction

endpackage

@@ hdl/json_string_unescape_utf8_core.sv @@
// ============================================================================
// json_string_unescape_utf8_core: JSON string body to UTF-8 decoder
// Takes the bytes of a JSON string body, resolves its escapes including
// surrogate pairs, and delivers UTF-8 bytes and status results.
// ============================================================================
//
//  Channel | Handshake                 | Payload                       | Dir
//  --------+---------------------------+-------------------------------+----
//  input   | in_valid_i / in_stall_o   | in_i  (kind, in_byte)         | in
//  output  | out_valid_o / out_stall_i | out_o (out_byte, status, last)| out
//
//  The front decoder accepts one input transaction per cycle while the job
//  queue has room; an item that causes no result pushes no job.
//  The back serializer delivers one output transaction per cycle while the
//  output is not stalled, so an item that causes n results gives n of them.
//  Sustained throughput is one item per cycle as long as the items average
//  at most one result; the four-entry job queue absorbs longer bursts.
//  On its way out the first result of an item passes through the job queue
//  and then the output register. Reset clears the decoder state, the queue
//  count and pointers and the output valid flag, not the job store or the
//  output data; no clearing pass is needed. A stall on the output holds the
//  registered result; input stalls come only from a full job queue.
//
module json_string_unescape_utf8_core import jsu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_o
);

  // Job hand-off between the decoder and the queue.
  logic      push;
  job_t      push_job;

  // Queue head seen by the back, status seen by both sides.
  job_t      head_job;
  q_status_t q_status;
  logic      pop;

  // The front runs the escape state machine and packs all results of one
  // transaction, at most four, into a single job.
  jsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (push_job)
  );

  // The queue decouples the two sides so each can stall on its own.
  jsu_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (push_job),
    .pop_i    (pop),
    .head_o   (head_job),
    .status_o (q_status)
  );

  // The back splits each job into output transactions and flags the last
  // one so the consumer can tell where one input item's results end.
  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_job),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

@@ hdl/jsu_front.sv @@
// ============================================================================
// jsu_front: input decoder of the JSON string unescape core
// Runs the escape state machine on each accepted input item and turns the
// results it causes into one job for the queue.
// ============================================================================
module jsu_front import jsu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_i,
  input  q_status_t q_status_i,
  output logic      push_o,
  output job_t      job_o
);

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_BODY = 2'd1;
  localparam logic [1:0] MODE_ESC  = 2'd2;
  localparam logic [1:0] MODE_HEX  = 2'd3;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChLowB   = 8'h62;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChLowN   = 8'h6E;
  localparam logic [7:0] ChLowR   = 8'h72;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChLowU   = 8'h75;

  logic [1:0]  mode_q, mode_d;
  logic [1:0]  hex_cnt_q, hex_cnt_d;
  logic [15:0] hex_acc_q, hex_acc_d;
  logic [15:0] pend_q, pend_d;
  logic        pend_vld_q, pend_vld_d;

  logic        accept;
  logic [7:0]  c;
  logic        hex_ok;
  logic [3:0]  hex_dig;
  logic [15:0] cp;
  logic [20:0] joined;
  enc_t        pend_enc;
  logic        fail;
  logic [2:0]  fail_st;
  logic        esc_ok;
  logic [7:0]  esc_byte;

  // Places the flushed bytes first and an optional extra result after them.
  function automatic job_t make_job(input enc_t e, input logic add, input res_t extra);
    job_t       j;
    logic [2:0] tot;
    j = '0;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < e.cnt) begin
        j.res[i] = {e.bytes[i], ST_DATA};
      end else if (add && 3'(i) == e.cnt) begin
        j.res[i] = extra;
      end
    end
    tot        = e.cnt + {2'b00, add};
    j.last_idx = tot[1:0] - 2'd1;
    return j;
  endfunction

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;
  assign c          = in_i.in_byte;

  always_comb begin
    hex_ok  = 1'b1;
    hex_dig = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_dig = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      hex_dig = c[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    esc_ok = 1'b1;
    unique case (c)
      ChLowB:                     esc_byte = 8'h08;
      ChLowF:                     esc_byte = 8'h0C;
      ChLowN:                     esc_byte = 8'h0A;
      ChLowR:                     esc_byte = 8'h0D;
      ChLowT:                     esc_byte = 8'h09;
      ChQuote, ChBslash, ChSlash: esc_byte = c;
      default: begin
        esc_byte = 8'h00;
        esc_ok   = 1'b0;
      end
    endcase
  end

  assign cp     = {hex_acc_q[11:0], hex_dig};
  assign joined = {1'b0, pend_q[9:0], cp[9:0]} + 21'h10000;

  always_comb begin
    if (pend_vld_q) begin
      pend_enc = utf8_encode({5'd0, pend_q});
    end else begin
      pend_enc = '0;
    end
  end

  always_comb begin
    mode_d     = mode_q;
    hex_cnt_d  = hex_cnt_q;
    hex_acc_d  = hex_acc_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    push_o     = 1'b0;
    job_o      = '0;
    fail       = 1'b0;
    fail_st    = ST_EOF;
    if (accept) begin
      if (in_i.kind == KIND_START) begin
        mode_d     = MODE_BODY;
        hex_cnt_d  = 2'd0;
        hex_acc_d  = '0;
        pend_d     = '0;
        pend_vld_d = 1'b0;
      end else if (in_i.kind == KIND_END) begin
        if (mode_q != MODE_IDLE) begin
          fail    = 1'b1;
          fail_st = (mode_q == MODE_HEX) ? ST_BADU : ST_EOF;
        end
      end else if (in_i.kind == KIND_BYTE) begin
        unique case (mode_q)
          MODE_IDLE: begin
          end
          MODE_BODY: begin
            if (c == ChQuote) begin
              job_o      = make_job(pend_enc, 1'b1, {8'h00, ST_CLOSE});
              push_o     = 1'b1;
              pend_d     = '0;
              pend_vld_d = 1'b0;
              mode_d     = MODE_IDLE;
            end else if (c < 8'h20) begin
              fail    = 1'b1;
              fail_st = ST_CTRL;
            end else if (c == ChBslash) begin
              mode_d = MODE_ESC;
            end else begin
              job_o      = make_job(pend_enc, 1'b1, {c, ST_DATA});
              push_o     = 1'b1;
              pend_d     = '0;
              pend_vld_d = 1'b0;
            end
          end
          MODE_ESC: begin
            if (c == ChLowU) begin
              mode_d    = MODE_HEX;
              hex_cnt_d = 2'd0;
              hex_acc_d = '0;
            end else if (!esc_ok) begin
              fail    = 1'b1;
              fail_st = ST_BADESC;
            end else begin
              job_o      = make_job(pend_enc, 1'b1, {esc_byte, ST_DATA});
              push_o     = 1'b1;
              pend_d     = '0;
              pend_vld_d = 1'b0;
              mode_d     = MODE_BODY;
            end
          end
          MODE_HEX: begin
            if (!hex_ok) begin
              fail    = 1'b1;
              fail_st = ST_BADU;
            end else if (hex_cnt_q != 2'd3) begin
              hex_acc_d = cp;
              hex_cnt_d = hex_cnt_q + 2'd1;
            end else begin
              if (pend_vld_q && pend_q[15:10] == 6'b110110 && cp[15:10] == 6'b110111) begin
                // High surrogate held back and a low one right after it.
                job_o      = make_job(utf8_encode(joined), 1'b0, '0);
                push_o     = 1'b1;
                pend_d     = '0;
                pend_vld_d = 1'b0;
              end else begin
                job_o      = make_job(pend_enc, 1'b0, '0);
                push_o     = pend_vld_q;
                pend_d     = cp;
                pend_vld_d = 1'b1;
              end
              hex_cnt_d = 2'd0;
              hex_acc_d = '0;
              mode_d    = MODE_BODY;
            end
          end
        endcase
      end
    end
    if (fail) begin
      // Any error gives a single result and drops all state.
      job_o        = '0;
      job_o.res[0] = {8'h00, fail_st};
      push_o       = 1'b1;
      mode_d       = MODE_IDLE;
      hex_cnt_d    = 2'd0;
      hex_acc_d    = '0;
      pend_d       = '0;
      pend_vld_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      hex_cnt_q  <= 2'd0;
      hex_acc_q  <= '0;
      pend_q     <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      hex_cnt_q  <= hex_cnt_d;
      hex_acc_q  <= hex_acc_d;
      pend_q     <= pend_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  // An error job always holds exactly one result.
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && job_o.res[0].status != ST_DATA && job_o.res[0].status != ST_CLOSE
    |-> job_o.last_idx == 2'd0)
    else $error("error job with more than one result");

  // Collecting hex digits only happens in the hex mode.
  a_hex_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hex_cnt_q != 2'd0 |-> mode_q == MODE_HEX)
    else $error("hex digit count outside of hex mode");

endmodule

@@ hdl/jsu_queue.sv @@
// ============================================================================
// jsu_queue: job queue between front decoder and back serializer
// A small FIFO of complete jobs, one push and one pop per cycle.
// ============================================================================
module jsu_queue import jsu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  job_t      job_i,
  input  logic      pop_i,
  output job_t      head_o,
  output q_status_t status_o
);

  job_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign status_o.full  = (cnt_q == QCntW'(QueueDepth));
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      cnt_q <= cnt_q + QCntW'(push_i) - QCntW'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("push into a full job queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("pop from an empty job queue");

endmodule

@@ hdl/jsu_back.sv @@
// ============================================================================
// jsu_back: result serializer of the JSON string unescape core
// Sends the results of the head job one per cycle, unless the output stalls,
// through an output register and marks the last one of each job.
// ============================================================================
module jsu_back import jsu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_t      head_i,
  input  q_status_t q_status_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_o
);

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;
  logic       load;
  logic       at_last;

  assign load    = !out_valid_q || !out_stall_i;
  assign at_last = (idx_q == head_i.last_idx);

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = !q_status_i.empty;
      out_d       = {head_i.res[idx_q].out_byte, head_i.res[idx_q].status, at_last};
      if (!q_status_i.empty) begin
        if (at_last) begin
          pop_o = 1'b1;
          idx_d = 2'd0;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // The result index never runs past the job it works on.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_status_i.empty |-> idx_q <= head_i.last_idx)
    else $error("result index beyond end of job");

endmodule

@@ tb/tb_json_string_unescape_utf8_core.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_json_string_unescape_utf8_core: self-checking bench for the JSON unescape
// The bench feeds string bodies made of plain bytes, simple escapes and
// \uXXXX escapes (surrogate pairs among them), broken with control bytes, bad
// escapes and early ends. A model of the decoder inside the bench predicts
// every result, and each output transaction is checked against it in order.
// ============================================================================
module tb_json_string_unescape_utf8_core;
  import jsu_pkg::*;

  // The unused kind code must be ignored by the core.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Characters that steer the decoder.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam int RandomTarget = 385;  // input transactions in the random part
  localparam int DrainCycles  = 16;   // settle time after the last result
  localparam int QuietLimit   = 1000; // cycles without any transaction
  localparam int HoldoffLen   = 60;   // long receiver stall
  localparam int HoldoffAt    = 150;  // input count that starts the long stall

  typedef enum logic [2:0] {
    DEC_IDLE,
    DEC_BODY,
    DEC_ESC,
    DEC_HEX
  } dec_mode_e;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_i        = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_o;

  json_string_unescape_utf8_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Decoder model. It mirrors the state that the core keeps: the parse mode,
  // the hex digits of a \u escape collected so far, and one escaped code
  // point held back so that a high surrogate can meet its low partner.
  // --------------------------------------------------------------------------
  dec_mode_e   dec_mode     = DEC_IDLE;
  logic [1:0]  dec_digits   = '0;
  logic [15:0] dec_accum    = '0;
  logic [15:0] held_point   = '0;
  logic        held_valid   = 1'b0;

  out_item_t   step_q[$];    // results of the transaction being modeled
  out_item_t   decoded_q[$]; // results still owed by the core, oldest first
  in_item_t    raw_items_q[$];

  int unsigned items_taken  = 0;
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned holdoff_left = 0;
  logic        holdoff_done = 1'b0;
  logic        quiet_stretch;

  function automatic int hex_digit_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // Byte that a simple escape stands for, with bit 8 set when the letter is
  // a valid simple escape. The \u escape is handled apart and reads as 0 here.
  function automatic logic [8:0] escape_target(logic [7:0] c);
    case (c)
      CH_B:                          return {1'b1, 8'h08};
      CH_F:                          return {1'b1, 8'h0C};
      CH_N:                          return {1'b1, 8'h0A};
      CH_R:                          return {1'b1, 8'h0D};
      CH_T:                          return {1'b1, 8'h09};
      CH_QUOTE, CH_BSLASH, CH_SLASH: return {1'b1, c};
      default:                       return 9'h000;
    endcase
  endfunction

  function automatic void emit_result(logic [7:0] b, logic [2:0] st);
    out_item_t r;
    r.out_byte = b;
    r.status   = st;
    r.last     = 1'b0;
    step_q = {step_q, r};
  endfunction

  // UTF-8 bytes of one code point, lead byte first.
  function automatic void emit_point(logic [20:0] pt);
    if (pt < 21'h80) begin
      emit_result(pt[7:0], ST_DATA);
    end else if (pt < 21'h800) begin
      emit_result(8'hC0 | 8'(pt >> 6), ST_DATA);
      emit_result(8'h80 | 8'(pt & 21'h3F), ST_DATA);
    end else if (pt < 21'h10000) begin
      emit_result(8'hE0 | 8'((pt >> 12) & 21'h0F), ST_DATA);
      emit_result(8'h80 | 8'((pt >> 6) & 21'h3F), ST_DATA);
      emit_result(8'h80 | 8'(pt & 21'h3F), ST_DATA);
    end else begin
      emit_result(8'hF0 | 8'((pt >> 18) & 21'h07), ST_DATA);
      emit_result(8'h80 | 8'((pt >> 12) & 21'h3F), ST_DATA);
      emit_result(8'h80 | 8'((pt >> 6) & 21'h3F), ST_DATA);
      emit_result(8'h80 | 8'(pt & 21'h3F), ST_DATA);
    end
  endfunction

  function automatic void flush_held();
    if (held_valid) emit_point({5'd0, held_point});
    held_valid = 1'b0;
    held_point = '0;
  endfunction

  function automatic void clear_decoder();
    dec_mode   = DEC_IDLE;
    dec_digits = '0;
    dec_accum  = '0;
    held_point = '0;
    held_valid = 1'b0;
  endfunction

  // An error drops everything, reports exactly one status and parks the
  // decoder until the next start.
  function automatic void abort_string(logic [2:0] st);
    clear_decoder();
    step_q.delete();
    emit_result(8'h00, st);
  endfunction

  // Advances the model by one accepted input transaction and queues the
  // results it owes, with last set on the final one.
  function automatic void decode_item(in_item_t it);
    logic [8:0]  esc;
    logic [15:0] cp;
    logic [20:0] joined;
    int          d;
    step_q.delete();
    case (it.kind)
      KIND_START: begin
        // A start in mid-string silently drops any held code point.
        clear_decoder();
        dec_mode = DEC_BODY;
      end
      KIND_END: begin
        if (dec_mode == DEC_HEX) abort_string(ST_BADU);
        else if (dec_mode != DEC_IDLE) abort_string(ST_EOF);
      end
      KIND_BYTE: begin
        case (dec_mode)
          DEC_BODY: begin
            if (it.in_byte == CH_QUOTE) begin
              flush_held();
              emit_result(8'h00, ST_CLOSE);
              dec_mode = DEC_IDLE;
            end else if (it.in_byte < 8'h20) begin
              abort_string(ST_CTRL);
            end else if (it.in_byte == CH_BSLASH) begin
              dec_mode = DEC_ESC;
            end else begin
              flush_held();
              emit_result(it.in_byte, ST_DATA);
            end
          end
          DEC_ESC: begin
            esc = escape_target(it.in_byte);
            if (it.in_byte == CH_U) begin
              dec_mode   = DEC_HEX;
              dec_digits = '0;
              dec_accum  = '0;
            end else if (!esc[8]) begin
              abort_string(ST_BADESC);
            end else begin
              flush_held();
              emit_result(esc[7:0], ST_DATA);
              dec_mode = DEC_BODY;
            end
          end
          DEC_HEX: begin
            d = hex_digit_value(it.in_byte);
            if (d < 0) begin
              abort_string(ST_BADU);
            end else begin
              dec_accum = {dec_accum[11:0], 4'(d)};
              if (dec_digits != 2'd3) begin
                dec_digits = dec_digits + 2'd1;
              end else begin
                cp = dec_accum;
                // Join only a held high surrogate with an escaped low one
                // that follows at once; anything else flushes the held point.
                if (held_valid && held_point >= 16'hD800 && held_point <= 16'hDBFF &&
                    cp >= 16'hDC00 && cp <= 16'hDFFF) begin
                  joined = (((21'(held_point) - 21'hD800) << 10) |
                            (21'(cp) - 21'hDC00)) + 21'h10000;
                  emit_point(joined);
                  held_valid = 1'b0;
                  held_point = '0;
                end else begin
                  flush_held();
                  held_point = cp;
                  held_valid = 1'b1;
                end
                dec_digits = '0;
                dec_accum  = '0;
                dec_mode   = DEC_BODY;
              end
            end
          end
          default: ; // idle: string bytes are dropped
        endcase
      end
      default: ; // unused kind: no result, no state change
    endcase
    if (step_q.size() != 0) step_q[step_q.size() - 1].last = 1'b1;
    decoded_q = {decoded_q, step_q};
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders.
  // --------------------------------------------------------------------------
  function automatic void add_item(logic [1:0] kind, logic [7:0] b);
    in_item_t it;
    it.kind    = kind;
    it.in_byte = b;
    raw_items_q = {raw_items_q, it};
  endfunction

  // Hex digit in random letter case.
  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'("0") + 8'(v);
    return (($urandom & 1) ? 8'("a") : 8'("A")) + 8'(v - 4'd10);
  endfunction

  function automatic void add_u_escape(logic [15:0] pt);
    add_item(KIND_BYTE, CH_BSLASH);
    add_item(KIND_BYTE, CH_U);
    for (int i = 3; i >= 0; i--) add_item(KIND_BYTE, hex_char(pt[i*4 +: 4]));
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(8'h20, 8'hFF));
    while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  // A \u escape with 0 to 3 good digits and then an offending input.
  function automatic void add_short_u(logic use_end);
    logic [7:0] b;
    int         k;
    k = $urandom_range(0, 3);
    add_item(KIND_BYTE, CH_BSLASH);
    add_item(KIND_BYTE, CH_U);
    for (int i = 0; i < k; i++) add_item(KIND_BYTE, hex_char(4'($urandom)));
    if (use_end) begin
      add_item(KIND_END, 8'($urandom));
    end else begin
      do b = 8'($urandom);
      while (hex_digit_value(b) >= 0);
      add_item(KIND_BYTE, b);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Shared pacing. Both sides stop idling for a stretch in the middle of
  // the run so that back-to-back traffic is seen too.
  // --------------------------------------------------------------------------
  assign quiet_stretch = (items_taken >= 260) && (items_taken < 340);

  // --------------------------------------------------------------------------
  // Driver: offers the queued items, holds a stalled transaction unchanged
  // and runs the model on every accepted one.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_i       <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        decode_item(in_i);
        items_taken <= items_taken + 1;
      end
      if (in_valid_i && in_stall_o) begin
        // The core is full; keep offering the same transaction.
      end else if (raw_items_q.size() != 0 &&
                   (quiet_stretch || $urandom_range(0, 99) >= 16)) begin
        in_i       <= raw_items_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each output transaction against the oldest predicted
  // result and drives the output stall. Once, after some traffic, it holds
  // the core off for a long stretch while the driver keeps pushing, so the
  // job queue fills and the input side has to stall.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result byte %h status %0d last %b",
                     $realtime, out_o.out_byte, out_o.status, out_o.last);
          mismatches <= mismatches + 1;
        end else begin
          want = decoded_q.pop_front();
          if (out_o.out_byte !== want.out_byte || out_o.status !== want.status ||
              out_o.last !== want.last) begin
            if (mismatches < 10)
              $display("%0t: expected byte %h status %0d last %b, got byte %h status %0d last %b",
                       $realtime, want.out_byte, want.status, want.last,
                       out_o.out_byte, out_o.status, out_o.last);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (holdoff_left != 0) begin
        holdoff_left <= holdoff_left - 1;
        out_stall_i  <= 1'b1;
      end else if (!holdoff_done && items_taken >= HoldoffAt) begin
        holdoff_left <= HoldoffLen - 1;
        holdoff_done <= 1'b1;
        out_stall_i  <= 1'b1;
      end else begin
        out_stall_i <= !quiet_stretch && ($urandom_range(0, 99) < 16);
      end
    end
  end

  // Watchdog: a correct run never goes this long without a transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("json_string_unescape_utf8_core verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // --------------------------------------------------------------------------
  initial begin
    logic [15:0] pt;
    logic [8:0]  esc_chk;
    int          sel;
    int          ntok;
    int          target;

    // Directed part: field extremes, every kind, and each corner of the
    // decoder that a short sequence can reach.
    add_item(KIND_START, 8'h00);
    add_item(KIND_BYTE, 8'hFF);          // high byte passes through as data
    add_item(KIND_BYTE, 8'h00);          // control byte
    add_item(KIND_BYTE, "a");            // idle: dropped
    add_item(KIND_END, 8'hFF);           // idle: no result
    add_item(KIND_UNUSED, 8'hFF);        // unused kind
    add_item(KIND_START, 8'hFF);
    add_item(KIND_BYTE, CH_BSLASH);
    add_item(KIND_BYTE, "q");            // bad escape letter
    add_item(KIND_START, 8'h00);
    add_item(KIND_BYTE, CH_BSLASH);
    add_item(KIND_BYTE, CH_U);
    add_item(KIND_BYTE, "1");
    add_item(KIND_BYTE, "g");            // bad hex digit
    add_item(KIND_START, 8'h00);
    add_item(KIND_BYTE, CH_BSLASH);
    add_item(KIND_BYTE, CH_U);
    add_item(KIND_END, 8'h00);           // end while collecting hex digits
    add_item(KIND_START, 8'h00);
    add_item(KIND_END, 8'h00);           // end in the body
    add_item(KIND_START, 8'h00);
    add_item(KIND_BYTE, CH_BSLASH);
    add_item(KIND_END, 8'h00);           // end right after a backslash
    add_item(KIND_START, 8'h00);
    add_item(KIND_BYTE, CH_QUOTE);       // empty string

    // Random part: mostly well-formed strings with random content, a good
    // share of them cut short by one of the error cases.
    target = raw_items_q.size() + RandomTarget;
    while (raw_items_q.size() < target) begin
      add_item(KIND_START, 8'($urandom));
      ntok = $urandom_range(1, 8);
      for (int t = 0; t < ntok; t++) begin
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
          add_item(KIND_BYTE, plain_byte());
        end else if (sel < 48) begin
          case ($urandom_range(0, 7))
            0:       pt[7:0] = CH_B;
            1:       pt[7:0] = CH_F;
            2:       pt[7:0] = CH_N;
            3:       pt[7:0] = CH_R;
            4:       pt[7:0] = CH_T;
            5:       pt[7:0] = CH_QUOTE;
            6:       pt[7:0] = CH_BSLASH;
            default: pt[7:0] = CH_SLASH;
          endcase
          add_item(KIND_BYTE, CH_BSLASH);
          add_item(KIND_BYTE, pt[7:0]);
        end else if (sel < 63) begin
          // Surrogate pair, joined into one four-byte character.
          add_u_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
          add_u_escape(16'($urandom_range(16'hDC00, 16'hDFFF)));
        end else if (sel < 90) begin
          case ($urandom_range(0, 5))
            0:       pt = 16'($urandom_range(0, 16'h7F));
            1:       pt = 16'($urandom_range(16'h80, 16'h7FF));
            2:       pt = 16'($urandom_range(16'h800, 16'hD7FF));
            3:       pt = 16'($urandom_range(16'hD800, 16'hDBFF));
            4:       pt = 16'($urandom_range(16'hDC00, 16'hDFFF));
            default: pt = 16'($urandom);
          endcase
          add_u_escape(pt);
        end else if (sel < 95) begin
          add_item(KIND_UNUSED, 8'($urandom));
        end else begin
          // High surrogate that is not followed by an escape stays lone.
          add_u_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
          add_item(KIND_BYTE, plain_byte());
        end
      end
      sel = $urandom_range(0, 99);
      if (sel < 62) begin
        add_item(KIND_BYTE, CH_QUOTE);
      end else if (sel < 68) begin
        add_item(KIND_BYTE, 8'($urandom_range(0, 8'h1F)));
      end else if (sel < 74) begin
        do begin
          pt[7:0] = 8'($urandom);
          esc_chk = escape_target(pt[7:0]);
        end while (esc_chk[8] || pt[7:0] == CH_U);
        add_item(KIND_BYTE, CH_BSLASH);
        add_item(KIND_BYTE, pt[7:0]);
      end else if (sel < 80) begin
        add_short_u(1'b0);
      end else if (sel < 86) begin
        add_short_u(1'b1);
      end else if (sel < 90) begin
        add_item(KIND_END, 8'($urandom));
      end else if (sel < 94) begin
        add_item(KIND_BYTE, CH_BSLASH);
        add_item(KIND_END, 8'($urandom));
      end
      // Otherwise the next start cuts the string off without a result, unless the stray byte and end below come first.
      if ($urandom_range(0, 9) == 0) begin
        add_item(KIND_BYTE, 8'($urandom));
        add_item(KIND_END, 8'($urandom));
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (raw_items_q.size() != 0 || in_valid_i || decoded_q.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("json_string_unescape_utf8_core verification clean");
    end else begin
      $display("json_string_unescape_utf8_core verification failed");
    end
    $finish;
  end

endmodule

@@ json_string_unescape_utf8_core.f @@
hdl/jsu_pkg.sv
hdl/jsu_front.sv
hdl/jsu_queue.sv
hdl/jsu_back.sv
hdl/json_string_unescape_utf8_core.sv
tb/tb_json_string_unescape_utf8_core.sv
